// ===== sv/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// Types and constants shared by the AArch64 relocation patcher and its checker.
// ----------------------------------------------------------------------------
package arp_pkg;

	localparam int unsigned STUB_BYTES = 16;

	// relocation types
	localparam logic [15:0] R_NONE            = 16'd0;
	localparam logic [15:0] R_ABS64           = 16'd257;
	localparam logic [15:0] R_ABS32           = 16'd258;
	localparam logic [15:0] R_ABS16           = 16'd259;
	localparam logic [15:0] R_PREL64          = 16'd260;
	localparam logic [15:0] R_PREL32          = 16'd261;
	localparam logic [15:0] R_PREL16          = 16'd262;
	localparam logic [15:0] R_MOVW_UABS_G0_NC = 16'd264;
	localparam logic [15:0] R_ADR_PREL_LO21   = 16'd274;
	localparam logic [15:0] R_ADR_PREL_PG_HI21 = 16'd275;
	localparam logic [15:0] R_ADD_ABS_LO12_NC = 16'd277;
	localparam logic [15:0] R_LDST8_LO12_NC   = 16'd278;
	localparam logic [15:0] R_TSTBR14         = 16'd279;
	localparam logic [15:0] R_CONDBR19        = 16'd280;
	localparam logic [15:0] R_JUMP26          = 16'd282;
	localparam logic [15:0] R_CALL26          = 16'd283;
	localparam logic [15:0] R_LDST16_LO12_NC  = 16'd284;
	localparam logic [15:0] R_LDST32_LO12_NC  = 16'd285;
	localparam logic [15:0] R_LDST64_LO12_NC  = 16'd286;
	localparam logic [15:0] R_LDST128_LO12_NC = 16'd299;

	// status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_RANGE       = 2'd1;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
	localparam logic [1:0] ST_STUB_FULL   = 2'd3;

	// write sizes
	localparam logic [3:0] SZ_NONE = 4'd0;
	localparam logic [3:0] SZ_2    = 4'd2;
	localparam logic [3:0] SZ_4    = 4'd4;
	localparam logic [3:0] SZ_8    = 4'd8;

	// register index (paddr[3])
	localparam logic REG_STUB_BASE = 1'b0;

	// trampoline: ldr x16, .+8 ; br x16
	localparam logic [31:0] STUB_LDR = 32'h58000050;
	localparam logic [31:0] STUB_BR  = 32'hd61f0200;

	localparam logic [31:0] ADR_KEEP  = 32'h9f00001f;
	localparam logic [31:0] B26_KEEP  = 32'hfc000000;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_LITERAL,
		PH_BRANCH
	} phase_t;

	typedef struct packed {
		logic [63:0] addr;
		logic [63:0] data;
		logic [3:0]  size;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// v read as signed lies in [-2^bits, 2^bits)
	function automatic logic fits(input logic [63:0] v, input int unsigned bits);
		logic [63:0] hi;
		hi = $unsigned($signed(v) >>> bits);
		return (hi == '0) || (hi == '1);
	endfunction

	function automatic logic [31:0] lo12(input logic [31:0] w, input logic [11:0] x,
			input int unsigned scale);
		logic [11:0] v;
		v = x >> scale;
		return (w & ~(32'hfff << 10)) | ({20'd0, v} << 10);
	endfunction

	function automatic logic [31:0] adr_imm(input logic [31:0] w, input logic [20:0] v);
		return (w & ADR_KEEP) | ({30'd0, v[1:0]} << 29) | ({13'd0, v[20:2]} << 5);
	endfunction

endpackage

// ===== sv/aarch64_relocation_patcher_core.sv =====
// ----------------------------------------------------------------------------
// aarch64_relocation_patcher_core
// Turns ELF64 RELA relocations into patch writes, with long-branch stubs.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  in       | in_valid / in_stall    | mode, place_address, symbol_value, addend, old_word
//  out      | out_valid / out_stall  | write_address, write_data, write_size, status, last
//  cfg      | APB psel/penable/pwrite| paddr, pwdata, prdata (stub_base at 0)
//
//  One item per cycle while out_stall is low, but not while an item that needs a trampoline stub is in decode.
//  Pipeline: input register, S+A add, then decode into the output register.
//  The stub sequencer holds the decode stage for its three writes.
//  Reset clears stub_base and the stub count; no clearing pass.
//  out_stall holds the output register and backs up to in_stall.
// ----------------------------------------------------------------------------
module aarch64_relocation_patcher_core
	import arp_pkg::*;
#(
	parameter int unsigned STUB_SLOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        mode,
	input  logic [63:0]        place_address,
	input  logic [63:0]        symbol_value,
	input  logic signed [63:0] addend,
	input  logic [31:0]        old_word,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        write_address,
	output logic [63:0]        write_data,
	output logic [3:0]         write_size,
	output logic [1:0]         status,
	output logic               last,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	localparam int unsigned CW = $clog2(STUB_SLOTS + 1);

	logic        s1_valid_q, s2_valid_q, out_valid_q;
	logic [15:0] mode_s1, mode_s2;
	logic [63:0] p_s1, p_s2, s_s1, a_s1, x_s2;
	logic [31:0] w_s1, w_s2;

	logic [63:0] stub_base_q, slot_q;
	logic [CW-1:0] count_q;
	phase_t      phase_q, phase_d;

	result_t     res, out_q;
	logic        fire, s2_load, accept, stub_use, cfg_wr;

	logic [63:0] r, sr, slot_lit;
	logic [51:0] pg;

	assign pready   = 1'b1;
	assign prdata   = stub_base_q;
	assign cfg_wr   = psel && penable && pwrite && (paddr[3] == REG_STUB_BASE);

	assign fire     = s2_valid_q && (!out_valid_q || !out_stall);
	assign s2_load  = !s2_valid_q || (fire && res.last);
	assign in_stall = s1_valid_q && !s2_load;
	assign accept   = in_valid && !in_stall;

	// decode stage
	assign r        = x_s2 - p_s2;
	assign sr       = slot_q - p_s2;
	assign pg       = x_s2[63:12] - p_s2[63:12];
	assign slot_lit = slot_q + 64'd8;
	assign stub_use = (mode_s2 inside {R_JUMP26, R_CALL26}) && !fits(r, 27)
		&& (count_q < CW'(STUB_SLOTS)) && fits(sr, 27);

	always_comb begin
		res = '{addr: p_s2, data: '0, size: SZ_4, status: ST_OK, last: 1'b1};
		case (phase_q)
			PH_LITERAL: begin
				res.addr = slot_lit;
				res.data = x_s2;
				res.size = SZ_8;
				res.last = 1'b0;
			end
			PH_BRANCH: begin
				res.data = {32'd0, (w_s2 & B26_KEEP) | {6'd0, sr[27:2]}};
			end
			default: begin
				case (mode_s2) inside
					R_NONE: begin
						res.addr = '0;
						res.size = SZ_NONE;
					end
					R_ABS64: begin
						res.data = x_s2;
						res.size = SZ_8;
					end
					R_ABS32: res.data = {32'd0, x_s2[31:0]};
					R_ABS16: begin
						res.data = {48'd0, x_s2[15:0]};
						res.size = SZ_2;
					end
					R_PREL64: begin
						res.data = r;
						res.size = SZ_8;
					end
					R_PREL32: res.data = {32'd0, r[31:0]};
					R_PREL16: begin
						res.data = {48'd0, r[15:0]};
						res.size = SZ_2;
					end
					R_MOVW_UABS_G0_NC:
						res.data = {32'd0, (w_s2 & ~(32'hffff << 5))
							| ({16'd0, x_s2[15:0]} << 5)};
					R_ADR_PREL_LO21: begin
						if (fits(r, 20)) begin
							res.data = {32'd0, adr_imm(w_s2, r[20:0])};
						end else begin
							res.status = ST_RANGE;
						end
					end
					R_ADR_PREL_PG_HI21: begin
						if (pg[51:20] == '0 || pg[51:20] == '1) begin
							res.data = {32'd0, adr_imm(w_s2, pg[20:0])};
						end else begin
							res.status = ST_RANGE;
						end
					end
					R_ADD_ABS_LO12_NC, R_LDST8_LO12_NC:
						res.data = {32'd0, lo12(w_s2, x_s2[11:0], 0)};
					R_LDST16_LO12_NC:  res.data = {32'd0, lo12(w_s2, x_s2[11:0], 1)};
					R_LDST32_LO12_NC:  res.data = {32'd0, lo12(w_s2, x_s2[11:0], 2)};
					R_LDST64_LO12_NC:  res.data = {32'd0, lo12(w_s2, x_s2[11:0], 3)};
					R_LDST128_LO12_NC: res.data = {32'd0, lo12(w_s2, x_s2[11:0], 4)};
					R_TSTBR14: begin
						if (fits(r, 15)) begin
							res.data = {32'd0, (w_s2 & ~(32'h3fff << 5))
								| ({18'd0, r[15:2]} << 5)};
						end else begin
							res.status = ST_RANGE;
						end
					end
					R_CONDBR19: begin
						if (fits(r, 20)) begin
							res.data = {32'd0, (w_s2 & ~(32'h7ffff << 5))
								| ({13'd0, r[20:2]} << 5)};
						end else begin
							res.status = ST_RANGE;
						end
					end
					R_JUMP26, R_CALL26: begin
						if (fits(r, 27)) begin
							res.data = {32'd0, (w_s2 & B26_KEEP) | {6'd0, r[27:2]}};
						end else if (count_q >= CW'(STUB_SLOTS)) begin
							res.status = ST_STUB_FULL;
						end else if (!fits(sr, 27)) begin
							res.status = ST_RANGE;
						end else begin
							res.addr = slot_q;
							res.data = {STUB_BR, STUB_LDR};
							res.size = SZ_8;
							res.last = 1'b0;
						end
					end
					default: res.status = ST_UNSUPPORTED;
				endcase
				if (res.status != ST_OK) begin
					res.addr = '0;
					res.data = '0;
					res.size = SZ_NONE;
				end
			end
		endcase
	end

	// stub sequencer
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			case (phase_q)
				PH_FIRST:   if (stub_use) phase_d = PH_LITERAL;
				PH_LITERAL: phase_d = PH_BRANCH;
				PH_BRANCH:  phase_d = PH_FIRST;
				default:    phase_d = PH_FIRST;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_FIRST;
			stub_base_q <= '0;
			slot_q      <= '0;
			count_q     <= '0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !s2_load);
			if (s2_load) s2_valid_q <= s1_valid_q;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			phase_q <= phase_d;
			if (cfg_wr) begin
				stub_base_q <= pwdata;
				slot_q      <= pwdata;
				count_q     <= '0;
			end else if (fire && phase_q == PH_BRANCH) begin
				slot_q  <= slot_q + 64'(STUB_BYTES);
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			p_s1    <= place_address;
			s_s1    <= symbol_value;
			a_s1    <= $unsigned(addend);
			w_s1    <= old_word;
		end
		if (s2_load && s1_valid_q) begin
			mode_s2 <= mode_s1;
			p_s2    <= p_s1;
			x_s2    <= s_s1 + a_s1;
			w_s2    <= w_s1;
		end
		if (fire) out_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign write_address = out_q.addr;
	assign write_data    = out_q.data;
	assign write_size    = out_q.size;
	assign status        = out_q.status;
	assign last          = out_q.last;

endmodule

// ===== sv/arp_checker.sv =====
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the relocation patcher's result stream.
// ----------------------------------------------------------------------------
module arp_checker
	import arp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  write_size,
	input logic [1:0]  status,
	input logic        last
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// only stub writes come before the final result
	a_mid_stub: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK && write_size == SZ_8)
		else $error("non-final result is not a stub write");

	// errors never write
	a_err_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> write_size == SZ_NONE && last)
		else $error("error result carries a write");

	// an accepted non-final stub write is followed by another result, with no gap
	a_stub_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("stub sequence broken");

endmodule

bind aarch64_relocation_patcher_core arp_checker u_arp_checker (.*);
